### hw/rtl/coc_pkg.sv
// Package for the CIDR overlap checker: types, codes and fixed constants.
`timescale 1ns / 1ps

package coc_pkg;

	// Maximum number of results reported for one check
	localparam int unsigned RESULT_CAP = 16;
	localparam int unsigned RESULT_CW  = $clog2(RESULT_CAP + 1);

	// Address and prefix widths
	localparam int unsigned ADDR_HALF_W = 64;
	localparam int unsigned V4_W        = 32;
	localparam int unsigned V6_W        = 128;
	localparam int unsigned PREFIX_W    = 8;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_CHECK = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_COMPARE,
		S_FINISH
	} state_t;

	// One input transaction
	typedef struct packed {
		action_t                  action;
		logic                     is_v6;
		logic [ADDR_HALF_W-1:0]   address_high;
		logic [ADDR_HALF_W-1:0]   address_low;
		logic [PREFIX_W-1:0]      prefix_len;
		logic                     tag;
	} req_t;

	// One result transaction
	typedef struct packed {
		logic       matched;
		logic [3:0] entry_index;
		logic       entry_tag;
		logic       status;
		logic       last;
	} rsp_t;

	// One stored protected prefix
	typedef struct packed {
		logic                     family;
		logic [ADDR_HALF_W-1:0]   addr_high;
		logic [ADDR_HALF_W-1:0]   addr_low;
		logic [PREFIX_W-1:0]      prefix;
		logic                     source;
	} entry_t;

endpackage

### hw/rtl/coc_prefix_match.sv
// Shared prefix compare unit: tests one stored entry against the route prefix.
`timescale 1ns / 1ps

module coc_prefix_match import coc_pkg::*; (
	input  entry_t                 entry,
	input  logic                   is_v6,
	input  logic [ADDR_HALF_W-1:0] address_high,
	input  logic [ADDR_HALF_W-1:0] address_low,
	input  logic [PREFIX_W-1:0]    prefix_len,
	output logic                   hit
);

	logic [PREFIX_W-1:0] eff_len;
	logic [PREFIX_W-1:0] v6_len;
	logic [V4_W-1:0]     mask_v4;
	logic [V6_W-1:0]     mask_v6;
	logic [V6_W-1:0]     diff_v6;
	logic [V4_W-1:0]     diff_v4;

	// Take the shorter prefix of the two
	assign eff_len = (prefix_len < entry.prefix) ? prefix_len : entry.prefix;

	// IPv4 mask: a length of 32 or more keeps every bit
	always_comb begin
		if (eff_len >= PREFIX_W'(V4_W)) begin
			mask_v4 = '1;
		end else begin
			mask_v4 = ~({V4_W{1'b1}} >> eff_len[4:0]);
		end
	end

	// IPv6 mask: saturate the length at 128
	assign v6_len  = (eff_len > PREFIX_W'(V6_W)) ? PREFIX_W'(V6_W) : eff_len;
	assign mask_v6 = ~({V6_W{1'b1}} >> v6_len);

	assign diff_v6 = {entry.addr_high, entry.addr_low} ^ {address_high, address_low};
	assign diff_v4 = entry.addr_low[V4_W-1:0] ^ address_low[V4_W-1:0];

	// Overlap only within the same family
	always_comb begin
		if (entry.family != is_v6) begin
			hit = 1'b0;
		end else if (is_v6) begin
			hit = ((diff_v6 & mask_v6) == '0);
		end else begin
			hit = ((diff_v4 & mask_v4) == '0);
		end
	end

endmodule

### hw/rtl/cidr_overlap_checker_unit.sv
// Top level of the CIDR overlap checker: entry table, scan sequencer, result register.
// Clear and add: the result is registered in FINISH once the output is free, and
// ready returns as it turns valid. Check: each entry is read, then compared, then
// finish; a result waiting on the output stalls the scan. At most one item in flight.
// Reset: table count zero, sequencer idle, no result valid; stored entries stay
// undefined until written, and no clearing pass runs.
`timescale 1ns / 1ps

module cidr_overlap_checker_unit import coc_pkg::*; #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned XW = (IW > 4) ? IW : 4;

	state_t state_q, state_d;

	logic [CW-1:0]          count_q;
	logic [IW-1:0]          idx_q;
	logic [RESULT_CW-1:0]   n_q;
	logic                   pend_valid_q;
	logic [IW-1:0]          pend_idx_q;
	logic                   pend_tag_q;
	logic                   status_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic                   req_v6_q;
	logic [ADDR_HALF_W-1:0] req_high_q;
	logic [ADDR_HALF_W-1:0] req_low_q;
	logic [PREFIX_W-1:0]    req_plen_q;

	entry_t                 mem_q [MAX_ENTRIES];
	entry_t                 rd_data_q;
	entry_t                 wr_entry;

	logic                   accept;
	logic                   full;
	logic                   out_free;
	logic                   hit;
	logic                   stall;
	logic                   emit_mid;
	logic                   emit_fin;
	logic                   rd_en;
	logic                   wr_en;
	logic                   last_entry;
	logic                   cap_reached;
	logic [CW-1:0]          idx_next;
	logic [ADDR_HALF_W-1:0] in_high;
	logic [ADDR_HALF_W-1:0] in_low;
	logic [XW-1:0]          pend_wide;

	assign accept   = req_valid && req_ready;
	assign full     = (count_q == CW'(MAX_ENTRIES));
	assign out_free = !rsp_valid_q || rsp_ready;
	assign idx_next = CW'(idx_q) + CW'(1);
	assign wr_en    = accept && (req.action == ACT_ADD) && !full;

	// Drop the unused address bits of an IPv4 transaction
	assign in_high = req.is_v6 ? req.address_high : '0;
	assign in_low  = req.is_v6 ? req.address_low
	                           : {{(ADDR_HALF_W-V4_W){1'b0}}, req.address_low[V4_W-1:0]};

	always_comb begin
		wr_entry.family    = req.is_v6;
		wr_entry.addr_high = in_high;
		wr_entry.addr_low  = in_low;
		wr_entry.prefix    = req.prefix_len;
		wr_entry.source    = req.tag;
	end

	// Compare the entry just read against the held route prefix
	coc_prefix_match u_match (
		.entry        (rd_data_q),
		.is_v6        (req_v6_q),
		.address_high (req_high_q),
		.address_low  (req_low_q),
		.prefix_len   (req_plen_q),
		.hit          (hit)
	);

	assign last_entry  = (idx_next >= count_q);
	assign cap_reached = hit && (n_q == RESULT_CW'(RESULT_CAP - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.action)
						ACT_CLEAR, ACT_ADD: state_d = S_FINISH;
						ACT_CHECK: state_d = (count_q == '0) ? S_FINISH : S_READ;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_READ: state_d = S_COMPARE;
			S_COMPARE: begin
				if (!stall) begin
					state_d = (last_entry || cap_reached) ? S_FINISH : S_READ;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		rd_en     = 1'b0;
		stall     = 1'b0;
		emit_mid  = 1'b0;
		emit_fin  = 1'b0;
		case (state_q)
			S_IDLE:    req_ready = 1'b1;
			S_READ:    rd_en = 1'b1;
			S_COMPARE: begin
				stall    = hit && pend_valid_q && !out_free;
				emit_mid = hit && pend_valid_q && out_free;
			end
			S_FINISH:  emit_fin = out_free;
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// Entry table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[count_q[IW-1:0]] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[idx_q];
		end
	end

	// Hold the route prefix of a check
	always_ff @(posedge clk) begin
		if (accept) begin
			req_v6_q   <= req.is_v6;
			req_high_q <= in_high;
			req_low_q  <= in_low;
			req_plen_q <= req.prefix_len;
		end
	end

	// Sequencer state, table count, scan position and pending match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			pend_idx_q   <= '0;
			pend_tag_q   <= 1'b0;
			status_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q        <= '0;
				n_q          <= '0;
				pend_valid_q <= 1'b0;
				status_q     <= (req.action == ACT_ADD) && full;
				if (req.action == ACT_CLEAR) begin
					count_q <= '0;
				end else if (wr_en) begin
					count_q <= count_q + CW'(1);
				end
			end else if (state_q == S_COMPARE && !stall) begin
				idx_q <= idx_q + IW'(1);
				if (hit) begin
					pend_valid_q <= 1'b1;
					pend_idx_q   <= idx_q;
					pend_tag_q   <= rd_data_q.source;
					n_q          <= n_q + RESULT_CW'(1);
				end
			end
		end
	end

	assign pend_wide = XW'(pend_idx_q);

	// Result register: release the older match mid-scan, the final one at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (emit_mid) begin
				rsp_valid_q       <= 1'b1;
				rsp_q.matched     <= 1'b1;
				rsp_q.entry_index <= pend_wide[3:0];
				rsp_q.entry_tag   <= pend_tag_q;
				rsp_q.status      <= 1'b0;
				rsp_q.last        <= 1'b0;
			end else if (emit_fin) begin
				rsp_valid_q       <= 1'b1;
				rsp_q.matched     <= pend_valid_q;
				rsp_q.entry_index <= pend_valid_q ? pend_wide[3:0] : 4'd0;
				rsp_q.entry_tag   <= pend_valid_q && pend_tag_q;
				rsp_q.status      <= status_q;
				rsp_q.last        <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
